// ----- hdl/bcc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and crc matrix helper for the bitstream crc32 checker
// no dependencies; imported by every module of the block

package bcc_pkg;

  localparam int CRC_W   = 32;
  localparam int WIF_W   = 7;
  localparam int FRAME_W = 13;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 2;
  localparam int OUT_W   = 48;

  localparam logic [CRC_W-1:0]   CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]   CRC_INIT_RST = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]   CRC_XOR_RST  = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]   EXP_CRC_RST  = 32'h0000_0000;

  localparam logic [WIF_W-1:0]   FRAME_WORDS  = 7'd101;
  localparam logic [FRAME_W-1:0] MAX_FRAMES   = 13'd4096;

  // command carried in tuser
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CRC_INIT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CRC_XOROUT = 2'd1;
  localparam logic [IDX_W-1:0] REG_EXP_CRC    = 2'd2;

  typedef struct packed {
    logic step;     // one data beat processed
    logic restart;  // finish beat processed
  } frm_ctl_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_total;
    logic               overflow;
  } frm_stat_t;

  // column of the 32-step crc shift matrix for input bit pos;
  // only ever called with constant arguments
  function automatic logic [CRC_W-1:0] crc_col(input int pos);
    logic [CRC_W-1:0] c;
    c = '0;
    c[pos] = 1'b1;
    for (int k = 0; k < CRC_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/bcc_crc_step.sv -----
`timescale 1ns / 1ps
// one 32-bit reflected crc step, bytes taken low first, as a parallel xor matrix
// depends on bcc_pkg

module bcc_crc_step import bcc_pkg::*; (
  input  logic [CRC_W-1:0] crc_in,
  input  logic [CRC_W-1:0] word_in,
  output logic [CRC_W-1:0] crc_out
);

  logic [CRC_W-1:0] mix;
  logic [CRC_W-1:0] term [CRC_W];

  // low byte first on a reflected crc equals xoring the whole word in up front
  assign mix = crc_in ^ word_in;

  for (genvar i = 0; i < CRC_W; i++) begin : g_col
    localparam logic [CRC_W-1:0] COL = crc_col(i);
    assign term[i] = mix[i] ? COL : '0;
  end

  always_comb begin
    crc_out = '0;
    for (int i = 0; i < CRC_W; i++) begin
      crc_out = crc_out ^ term[i];
    end
  end

endmodule

// ----- hdl/bcc_frame_cnt.sv -----
`timescale 1ns / 1ps
// word-in-frame and complete-frame counters with saturation flag
// depends on bcc_pkg

module bcc_frame_cnt import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  frm_ctl_t  ctl,
  output frm_stat_t stat
);

  logic [WIF_W-1:0]   wif_r,   wif_nxt;
  logic [FRAME_W-1:0] frames_r, frames_nxt;
  logic               ovf_r,   ovf_nxt;

  always_comb begin
    wif_nxt    = wif_r;
    frames_nxt = frames_r;
    ovf_nxt    = ovf_r;
    if (ctl.restart) begin
      wif_nxt    = '0;
      frames_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (ctl.step) begin
      if (wif_r == FRAME_WORDS - 7'd1) begin
        wif_nxt = '0;
        if (frames_r < MAX_FRAMES) begin
          frames_nxt = frames_r + 13'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        wif_nxt = wif_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wif_r    <= '0;
      frames_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      wif_r    <= wif_nxt;
      frames_r <= frames_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign stat.frame_total = frames_r;
  assign stat.overflow    = ovf_r;

endmodule

// ----- hdl/bitstream_crc32_checker.sv -----
`timescale 1ns / 1ps
// a finish beat passes through the input register and then the result register
// throughput: one beat per cycle; data beats never wait on the result side,
// a finish beat waits only while an earlier result is still held on out_
// the crc step is one 32-bit xor matrix between the input register and the crc register
// reset (rst_n low, synchronous): registers back to their standard values, crc restarts
// from 0xffffffff, counters and flags cleared, no beat held on either side

module bitstream_crc32_checker import bcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CRC_W-1:0] in_tdata,   // [31:0] data_word
  input  logic             in_tuser,   // [0] cmd
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // [31:0] crc_value, [44:32] frame_total,
                                       // [46:45] status, [47] zero
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0] cfg_data
);

  // configuration registers
  logic [CRC_W-1:0] crc_init_r, crc_init_nxt;
  logic [CRC_W-1:0] crc_xor_r,  crc_xor_nxt;
  logic [CRC_W-1:0] exp_crc_r,  exp_crc_nxt;

  // input register
  logic             in_valid_r, in_valid_nxt;
  logic             in_cmd_r,   in_cmd_nxt;
  logic [CRC_W-1:0] in_word_r,  in_word_nxt;

  // running crc
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] crc_stepped;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r,  out_data_nxt;

  logic             proc_go;
  logic             is_finish;
  logic             out_free;
  logic [CRC_W-1:0] crc_value;
  logic [STAT_W-1:0] status;
  frm_ctl_t         frm_ctl;
  frm_stat_t        frm_stat;

  // writes are always taken, unknown index ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    crc_init_nxt = crc_init_r;
    crc_xor_nxt  = crc_xor_r;
    exp_crc_nxt  = exp_crc_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CRC_INIT:   crc_init_nxt = cfg_data;
        REG_CRC_XOROUT: crc_xor_nxt  = cfg_data;
        REG_EXP_CRC:    exp_crc_nxt  = cfg_data;
        default:        ;
      endcase
    end
  end

  // result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign is_finish = (in_cmd_r == CMD_FINISH);
  // data beats always move on; a finish beat needs the result slot
  assign proc_go   = in_valid_r && (!is_finish || out_free);
  assign in_tready = !in_valid_r || proc_go;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_cmd_nxt   = in_cmd_r;
    in_word_nxt  = in_word_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
      in_cmd_nxt   = in_tuser;
      in_word_nxt  = in_tdata;
    end
  end

  bcc_crc_step u_crc_step (
    .crc_in  (crc_r),
    .word_in (in_word_r),
    .crc_out (crc_stepped)
  );

  assign frm_ctl.step    = proc_go && !is_finish;
  assign frm_ctl.restart = proc_go && is_finish;

  bcc_frame_cnt u_frame_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (frm_ctl),
    .stat  (frm_stat)
  );

  always_comb begin
    crc_nxt = crc_r;
    if (frm_ctl.restart) begin
      crc_nxt = crc_init_r;
    end else if (frm_ctl.step) begin
      crc_nxt = crc_stepped;
    end
  end

  // status priority: empty, then too many frames, then mismatch
  assign crc_value = crc_r ^ crc_xor_r;

  always_comb begin
    if (frm_stat.frame_total == '0) begin
      status = ST_EMPTY;
    end else if (frm_stat.overflow) begin
      status = ST_TOO_MANY;
    end else if ((exp_crc_r != '0) && (crc_value != exp_crc_r)) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (frm_ctl.restart) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, status, frm_stat.frame_total, crc_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r  <= CRC_INIT_RST;
      crc_xor_r   <= CRC_XOR_RST;
      exp_crc_r   <= EXP_CRC_RST;
      in_valid_r  <= 1'b0;
      crc_r       <= CRC_INIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      crc_init_r  <= crc_init_nxt;
      crc_xor_r   <= crc_xor_nxt;
      exp_crc_r   <= exp_crc_nxt;
      in_valid_r  <= in_valid_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    in_cmd_r   <= in_cmd_nxt;
    in_word_r  <= in_word_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a result only ever appears after a finish beat was processed
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_valid_r && is_finish))
    else $error("result appeared without a finish beat");

  // frame count never passes the limit
  a_frame_limit: assert property (@(posedge clk) disable iff (!rst_n)
    frm_stat.frame_total <= MAX_FRAMES)
    else $error("frame count beyond limit");

  // overflow only once the count is saturated
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    frm_stat.overflow |-> (frm_stat.frame_total == MAX_FRAMES))
    else $error("overflow flag without saturated count");

  // empty status goes with a zero frame total and nothing else
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[46:45] == ST_EMPTY) == (out_tdata[44:32] == '0)))
    else $error("empty status disagrees with frame total");

endmodule

// ----- dv/bitstream_crc32_checker_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for bitstream_crc32_checker: random and directed beats, a
// beat-level crc/frame predictor and an in-order scoreboard on the result stream
// depends on hdl/bcc_pkg.sv and hdl/bitstream_crc32_checker.sv

module bitstream_crc32_checker_tb;
  import bcc_pkg::*;

  localparam int IDLE_PCT    = 29;    // chance in a hundred that a side idles
  localparam int HOLD_CYCLES = 300;   // one long result back-pressure stretch
  localparam int LAT_SLACK   = 4;     // room for the input and result registers to drain
  localparam int STALL_LIMIT = 2000;  // cycles without any accepted beat
  localparam int PAD_LSB     = CRC_W + FRAME_W + STAT_W;

  // index that maps to no register, writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  // how a stream sets the expected crc before it starts
  typedef enum int {EXP_KEEP, EXP_OFF, EXP_MATCH, EXP_RAND, EXP_ONES} exp_mode_t;

  typedef struct {
    logic             cmd;
    logic [CRC_W-1:0] word;
  } stream_beat_t;

  typedef struct {
    logic [CRC_W-1:0]   crc;
    logic [FRAME_W-1:0] frames;
    logic [STAT_W-1:0]  status;
  } crc_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [CRC_W-1:0] in_tdata = '0;   // [31:0] data_word
  logic             in_tuser = 1'b0; // [0] cmd

  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // [31:0] crc_value, [44:32] frame_total,
                                     // [46:45] status, [47] zero

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CRC_W-1:0] cfg_data = '0;

  bitstream_crc32_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // beats waiting for the driver, and crc reports waiting for the result side
  stream_beat_t beat_backlog[$];
  crc_report_t  pending_reports[$];
  stream_beat_t next_beat;

  // flags raised by the stimulus, read by the driver and the receiver
  logic steady_flow = 1'b0;
  logic stall_request = 1'b0;

  int err_count = 0;
  int queued_beats = 0;
  int queued_finishes = 0;

  // predictor copy of the registers and of the checker state
  logic [CRC_W-1:0]   model_init   = CRC_INIT_RST;
  logic [CRC_W-1:0]   model_xorout = CRC_XOR_RST;
  logic [CRC_W-1:0]   model_expect = EXP_CRC_RST;
  logic [CRC_W-1:0]   model_crc    = CRC_INIT_RST;
  int                 model_wif    = 0;
  logic [FRAME_W-1:0] model_frames = '0;
  logic               model_over   = 1'b0;

  task automatic flag_error(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // one 32-bit word through the reflected crc, bit 0 of the low byte first
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] acc,
                                                input logic [CRC_W-1:0] word);
    logic fb;
    for (int i = 0; i < CRC_W; i++) begin
      fb  = acc[0] ^ word[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // advance the predictor by one accepted input beat
  task automatic absorb_beat(input logic cmd, input logic [CRC_W-1:0] word);
    crc_report_t r;
    if (cmd == CMD_DATA) begin
      model_crc = crc_fold(model_crc, word);
      model_wif = (model_wif + 1) % 128;
      if (model_wif >= FRAME_WORDS) begin
        model_wif = 0;
        // frame limit: once saturated further frames only raise the overflow flag
        if (model_frames < MAX_FRAMES) model_frames++;
        else model_over = 1'b1;
      end
    end else begin
      r.crc    = model_crc ^ model_xorout;
      r.frames = model_frames;
      // priority: empty, then too many frames, then a mismatch when checking is on
      if (model_frames == '0) r.status = ST_EMPTY;
      else if (model_over) r.status = ST_TOO_MANY;
      else if (model_expect != '0 && r.crc != model_expect) r.status = ST_MISMATCH;
      else r.status = ST_OK;
      pending_reports.push_back(r);
      // restart picks up whatever crc_init holds now
      model_crc    = model_init;
      model_wif    = 0;
      model_frames = '0;
      model_over   = 1'b0;
    end
  endtask

  task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
    case (idx)
      REG_CRC_INIT:   model_init   = val;
      REG_CRC_XOROUT: model_xorout = val;
      REG_EXP_CRC:    model_expect = val;
      default: ;
    endcase
  endtask

  task automatic check_report(input logic [OUT_W-1:0] beat);
    crc_report_t r;
    if (pending_reports.size() == 0) begin
      flag_error($sformatf("result beat %h with no report outstanding", beat));
    end else begin
      r = pending_reports.pop_front();
      if (beat[CRC_W-1:0] !== r.crc)
        flag_error($sformatf("crc_value %h, want %h", beat[CRC_W-1:0], r.crc));
      if (beat[CRC_W+FRAME_W-1:CRC_W] !== r.frames)
        flag_error($sformatf("frame_total %0d, want %0d",
                             beat[CRC_W+FRAME_W-1:CRC_W], r.frames));
      if (beat[PAD_LSB-1:CRC_W+FRAME_W] !== r.status)
        flag_error($sformatf("status %0d, want %0d",
                             beat[PAD_LSB-1:CRC_W+FRAME_W], r.status));
      if (beat[OUT_W-1:PAD_LSB] !== '0)
        flag_error($sformatf("pad bits %b not zero", beat[OUT_W-1:PAD_LSB]));
    end
  endtask

  // driver: presents the next backlog beat once the previous one has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (beat_backlog.size() != 0 &&
          (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_beat = beat_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_beat.word;
        in_tuser  <= next_beat.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold counted here
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (stall_request && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady_flow || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // monitor: results are checked before the predictor sees the beat of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_report(out_tdata);
      if (in_tvalid && in_tready) absorb_beat(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on progress of any channel
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bitstream_crc32_checker_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CRC_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // mostly short bitstreams, some with one to four complete frames
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 40) return $urandom_range(1, FRAME_WORDS - 1);
    if (r < 72) return FRAME_WORDS - 1 + $urandom_range(0, 4);
    if (r < 92) return 2 * FRAME_WORDS - 1 + $urandom_range(0, 30);
    return 3 * FRAME_WORDS + $urandom_range(0, FRAME_WORDS);
  endfunction

  function automatic exp_mode_t pick_mode();
    case ($urandom_range(0, 5))
      0:       return EXP_OFF;
      1:       return EXP_RAND;
      2:       return EXP_ONES;
      3, 4:    return EXP_MATCH;
      default: return EXP_KEEP;
    endcase
  endfunction

  function automatic logic [CRC_W-1:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input logic [CRC_W-1:0] w);
    stream_beat_t b;
    b.cmd  = CMD_DATA;
    b.word = w;
    beat_backlog.push_back(b);
    queued_beats++;
  endtask

  // the data field of a finish beat is don't-care, so it gets noise
  task automatic queue_finish();
    stream_beat_t b;
    b.cmd  = CMD_FINISH;
    b.word = $urandom;
    beat_backlog.push_back(b);
    queued_beats++;
    queued_finishes++;
  endtask

  // only called with the block idle; leaves the caller just after a falling edge
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait until the backlog is gone and every report has been seen, then let the
  // pipeline run dry since data beats leave no trace on the result side
  task automatic settle();
    do @(negedge clk);
    while (!(beat_backlog.size() == 0 && !in_tvalid && pending_reports.size() == 0));
    repeat (LAT_SLACK) @(negedge clk);
  endtask

  task automatic set_flow(input logic on);
    @(posedge clk);
    steady_flow <= on;
    @(negedge clk);
  endtask

  // one bitstream ending in a finish beat; the expected crc is set up first,
  // which needs the block idle unless the mode leaves it alone
  task automatic run_stream(input int n_words, input exp_mode_t mode);
    logic [CRC_W-1:0] words[$];
    logic [CRC_W-1:0] acc;
    logic [CRC_W-1:0] target;
    for (int i = 0; i < n_words; i++) words.push_back(pick_word());
    target = model_expect;
    case (mode)
      EXP_OFF:  target = '0;
      EXP_ONES: target = '1;
      EXP_RAND: target = $urandom;
      EXP_MATCH: begin
        // idle here, so the predictor state is what the block holds
        acc = model_crc;
        foreach (words[i]) acc = crc_fold(acc, words[i]);
        target = acc ^ model_xorout;
      end
      default: ;
    endcase
    if (mode != EXP_KEEP) write_reg(REG_EXP_CRC, target);
    foreach (words[i]) queue_word(words[i]);
    queue_finish();
  endtask

  initial begin
    int n_streams;
    int cut;
    int phase;
    int beats_mark;
    int finish_mark;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at reset values: immediate finish, then a partial frame with
    // all-zero and all-one words
    queue_finish();
    queue_word('0);
    queue_word('1);
    queue_word(32'h8000_0001);
    queue_finish();
    // one complete frame with the check disabled
    run_stream(FRAME_WORDS, EXP_KEEP);
    settle();

    // check enabled and matching, then a write to the unused index
    run_stream(FRAME_WORDS, EXP_MATCH);
    settle();
    write_reg(REG_SPARE, $urandom);
    run_stream(FRAME_WORDS + 7, EXP_ONES);
    settle();

    // new init only lands at the next restart: the first stream still starts
    // from the old value
    write_reg(REG_CRC_INIT, '0);
    write_reg(REG_CRC_XOROUT, '0);
    run_stream(FRAME_WORDS, EXP_OFF);
    run_stream(2 * FRAME_WORDS, EXP_KEEP);
    settle();

    // register writes in the middle of a bitstream
    for (int i = 0; i < 40; i++) queue_word(pick_word());
    settle();
    write_reg(REG_CRC_INIT, $urandom);
    write_reg(REG_CRC_XOROUT, $urandom);
    run_stream(2 * FRAME_WORDS - 40 + 3, EXP_MATCH);
    settle();

    // empty outranks a mismatch
    run_stream(5, EXP_RAND);
    settle();
    write_reg(REG_CRC_INIT, '1);
    write_reg(REG_CRC_XOROUT, '1);

    // long result hold while finishes keep coming: the block fills and stalls
    @(posedge clk);
    stall_request <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < 14; i++) run_stream($urandom_range(0, 4), EXP_KEEP);
    settle();

    // three complete frames and a partial one, full speed throughout
    write_reg(REG_EXP_CRC, $urandom | 32'h1);
    set_flow(1'b1);
    for (int i = 0; i < 3 * FRAME_WORDS + 5; i++) queue_word(pick_word());
    queue_finish();
    settle();
    set_flow(1'b0);

    // random phases: register changes between bitstreams, now and then mid-stream
    beats_mark  = queued_beats;
    finish_mark = queued_finishes;
    phase = 0;
    while (queued_beats - beats_mark < 400 || queued_finishes - finish_mark < 4) begin
      if (phase == 1) set_flow(1'b1);
      if (phase == 2) set_flow(1'b0);
      if ($urandom_range(0, 3) == 0) write_reg(REG_CRC_INIT, pick_reg_value());
      if ($urandom_range(0, 3) == 0) write_reg(REG_CRC_XOROUT, pick_reg_value());
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, $urandom);
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, FRAME_WORDS + 20);
        for (int i = 0; i < cut; i++) queue_word(pick_word());
        settle();
        write_reg(REG_CRC_INIT, pick_reg_value());
        write_reg(REG_CRC_XOROUT, pick_reg_value());
      end
      n_streams = $urandom_range(1, 3);
      for (int k = 0; k < n_streams; k++)
        run_stream(pick_length(), (k == 0) ? pick_mode() : EXP_KEEP);
      settle();
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("bitstream_crc32_checker_tb OK");
    end else begin
      $display("bitstream_crc32_checker_tb NOT OK");
    end
    $finish;
  end

endmodule
